// File: rtl/ipq_pkg.sv
// shared types and constants for the indexed min-heap priority queue
// command and result beat structs, operation and status codes
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package ipq_pkg;

  localparam int MAX_VERTICES = 1024;
  localparam int KEY_BITS     = 31;

  localparam int VERTEX_W = 10;
  localparam int KEY_W    = 31;
  localparam int COUNT_W  = 11;

  localparam logic [1:0] MODE_INSERT  = 2'd0;
  localparam logic [1:0] MODE_EXTRACT = 2'd1;
  localparam logic [1:0] MODE_SETKEY  = 2'd2;
  localparam logic [1:0] MODE_LOOKUP  = 2'd3;

  localparam logic [1:0] STAT_OK     = 2'd0;
  localparam logic [1:0] STAT_EMPTY  = 2'd1;
  localparam logic [1:0] STAT_FULL   = 2'd2;
  localparam logic [1:0] STAT_ABSENT = 2'd3;

  typedef struct packed {
    logic [1:0]          mode;
    logic [VERTEX_W-1:0] vertex;
    logic [KEY_W-1:0]    new_key;
  } cmd_t;

  typedef struct packed {
    logic [VERTEX_W-1:0] out_vertex;
    logic [KEY_W-1:0]    out_key;
    logic                present;
    logic [COUNT_W-1:0]  count;
    logic [1:0]          status;
  } res_t;

endpackage
`default_nettype wire

// File: rtl/ipq_ram.sv
// simple dual-port synchronous ram, one write and one read port
// read data registered; no package dependency
`timescale 1ns / 1ps
`default_nettype none
module ipq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic                     clk_i,
  input  wire logic                     wr_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  wire logic [WIDTH-1:0]         wr_data_i,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic      [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    rd_data_o <= mem[rd_addr_i];
  end

endmodule
`default_nettype wire

// File: rtl/indexed_min_heap_priority_queue.sv
// indexed binary min-heap; each command first reads the vertex map, then
// lookup and a duplicate insert read the key from the heap, insert writes at once;
// set-key sifts up, reading the parent at each level moved
// extract reads the root and last entry, then sifts down, reading both children
// the single read port of the heap ram makes these reads serial; one command at a time, busy
// stays high until the result beat is produced
// after reset a pass clears all 1024 vertex map entries, busy high throughout
// results are shown for one cycle on done_o; the receiver cannot stall
`timescale 1ns / 1ps
`default_nettype none
module indexed_min_heap_priority_queue #(
  parameter int MAX_VERTICES = ipq_pkg::MAX_VERTICES,
  parameter int KEY_BITS     = ipq_pkg::KEY_BITS
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start,
  input  wire ipq_pkg::cmd_t cmd_i,
  output logic               busy,
  output logic               done_o,
  output ipq_pkg::res_t      res_o
);

  localparam int AW = $clog2(MAX_VERTICES);       // heap slot index
  localparam int CW = $clog2(MAX_VERTICES + 1);   // entry count
  localparam int VW = ipq_pkg::VERTEX_W;
  localparam int NV = 1 << VW;                    // vertex map depth
  localparam int KW = KEY_BITS;
  localparam int EW = VW + KW;                    // heap entry: vertex, key
  localparam int SW = AW + 1;                     // map entry: here, slot

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_LOOK, ST_KEY, ST_EX0, ST_EX1,
    ST_SD_L, ST_SD_R, ST_SD_C, ST_SU, ST_SU_C
  } state_e;

  state_e              state_q, state_d;
  logic [VW-1:0]       clr_q, clr_d;
  logic [CW-1:0]       cnt_q, cnt_d;
  logic [1:0]          op_q, op_d;
  logic [VW-1:0]       v_q, v_d;
  logic [KW-1:0]       nk_q, nk_d;
  logic [AW-1:0]       idx_q, idx_d;
  logic [VW-1:0]       cur_v_q, cur_v_d;
  logic [KW-1:0]       cur_k_q, cur_k_d;
  logic [VW-1:0]       lv_q, lv_d;
  logic [KW-1:0]       lk_q, lk_d;
  logic                rok_q, rok_d;
  logic [VW-1:0]       rv_q, rv_d;
  logic [KW-1:0]       rk_q, rk_d;
  logic [1:0]          st_q, st_d;
  logic                done_q, done_d;
  ipq_pkg::res_t       res_q, res_d;

  // heap ram port signals
  logic                h_wr_en;
  logic [AW-1:0]       h_wr_addr, h_rd_addr;
  logic [EW-1:0]       h_wr_data, h_rd_data;
  // vertex map ram port signals
  logic                s_wr_en;
  logic [VW-1:0]       s_wr_addr, s_rd_addr;
  logic [SW-1:0]       s_wr_data, s_rd_data;

  ipq_ram #(.WIDTH(EW), .DEPTH(MAX_VERTICES)) u_heap (
    .clk_i    (clk_i),
    .wr_en_i  (h_wr_en),
    .wr_addr_i(h_wr_addr),
    .wr_data_i(h_wr_data),
    .rd_addr_i(h_rd_addr),
    .rd_data_o(h_rd_data)
  );

  ipq_ram #(.WIDTH(SW), .DEPTH(NV)) u_map (
    .clk_i    (clk_i),
    .wr_en_i  (s_wr_en),
    .wr_addr_i(s_wr_addr),
    .wr_data_i(s_wr_data),
    .rd_addr_i(s_rd_addr),
    .rd_data_o(s_rd_data)
  );

  logic          accept;
  logic          v_ok;
  logic          s_here;
  logic [AW-1:0] s_slot;
  logic [VW-1:0] rd_v;
  logic [KW-1:0] rd_k;
  logic [CW:0]   l_w, r_w;
  logic [AW-1:0] par;
  logic [CW-1:0] cnt_m1;

  assign accept = start && !busy;
  assign v_ok   = int'(v_q) < MAX_VERTICES;
  assign s_here = v_ok && s_rd_data[AW];
  assign s_slot = s_rd_data[AW-1:0];
  assign rd_v   = h_rd_data[EW-1:KW];
  assign rd_k   = h_rd_data[KW-1:0];
  // children and parent of the slot being moved
  assign l_w    = {idx_q, 1'b1} + (CW+1)'(0) ;
  assign r_w    = l_w + (CW+1)'(1);
  assign par    = AW'((idx_q - AW'(1)) >> 1);
  assign cnt_m1 = cnt_q - CW'(1);

  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    cnt_d   = cnt_q;
    op_d    = op_q;
    v_d     = v_q;
    nk_d    = nk_q;
    idx_d   = idx_q;
    cur_v_d = cur_v_q;
    cur_k_d = cur_k_q;
    lv_d    = lv_q;
    lk_d    = lk_q;
    rok_d   = rok_q;
    rv_d    = rv_q;
    rk_d    = rk_q;
    st_d    = st_q;
    done_d  = 1'b0;
    res_d   = res_q;

    h_wr_en   = 1'b0;
    h_wr_addr = idx_q;
    h_wr_data = {cur_v_q, cur_k_q};
    h_rd_addr = idx_q;
    s_wr_en   = 1'b0;
    s_wr_addr = cur_v_q;
    s_wr_data = {1'b1, idx_q};
    s_rd_addr = cmd_i.vertex;

    case (state_q)
      ST_CLEAR: begin
        // sweep the vertex map to all absent
        s_wr_en   = 1'b1;
        s_wr_addr = clr_q;
        s_wr_data = '0;
        clr_d     = clr_q + VW'(1);
        if (clr_q == '1) begin
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (start) begin
          op_d    = cmd_i.mode;
          v_d     = cmd_i.vertex;
          nk_d    = KW'(cmd_i.new_key);
          state_d = ST_LOOK;
        end
      end

      // map entry of the vertex is on the read port now
      ST_LOOK: begin
        res_d.out_vertex = v_q;
        res_d.out_key    = '0;
        res_d.present    = 1'b0;
        res_d.count      = ipq_pkg::COUNT_W'(cnt_q);
        case (op_q)
          ipq_pkg::MODE_INSERT: begin
            if (s_here) begin
              // duplicate: report its current key
              st_d      = ipq_pkg::STAT_FULL;
              h_rd_addr = s_slot;
              state_d   = ST_KEY;
            end else if (!v_ok || cnt_q >= CW'(MAX_VERTICES)) begin
              res_d.status = ipq_pkg::STAT_FULL;
              done_d       = 1'b1;
              state_d      = ST_IDLE;
            end else begin
              h_wr_en          = 1'b1;
              h_wr_addr        = AW'(cnt_q);
              h_wr_data        = {v_q, {KW{1'b1}}};
              s_wr_en          = 1'b1;
              s_wr_addr        = v_q;
              s_wr_data        = {1'b1, AW'(cnt_q)};
              cnt_d            = cnt_q + CW'(1);
              res_d.out_key    = ipq_pkg::KEY_W'({KW{1'b1}});
              res_d.present    = 1'b1;
              res_d.count      = ipq_pkg::COUNT_W'(cnt_q + CW'(1));
              res_d.status     = ipq_pkg::STAT_OK;
              done_d           = 1'b1;
              state_d          = ST_IDLE;
            end
          end
          ipq_pkg::MODE_EXTRACT: begin
            if (cnt_q == '0) begin
              res_d.out_vertex = '0;
              res_d.status     = ipq_pkg::STAT_EMPTY;
              done_d           = 1'b1;
              state_d          = ST_IDLE;
            end else begin
              h_rd_addr = '0;
              state_d   = ST_EX0;
            end
          end
          ipq_pkg::MODE_SETKEY: begin
            if (!s_here) begin
              res_d.status = ipq_pkg::STAT_ABSENT;
              done_d       = 1'b1;
              state_d      = ST_IDLE;
            end else begin
              cur_v_d = v_q;
              cur_k_d = nk_q;
              idx_d   = s_slot;
              state_d = ST_SU;
            end
          end
          ipq_pkg::MODE_LOOKUP: begin
            if (!s_here) begin
              res_d.status = ipq_pkg::STAT_ABSENT;
              done_d       = 1'b1;
              state_d      = ST_IDLE;
            end else begin
              st_d      = ipq_pkg::STAT_OK;
              h_rd_addr = s_slot;
              state_d   = ST_KEY;
            end
          end
          default: begin
            state_d = ST_IDLE;
          end
        endcase
      end

      ST_KEY: begin
        res_d.out_key = ipq_pkg::KEY_W'(rd_k);
        res_d.present = 1'b1;
        res_d.status  = st_q;
        done_d        = 1'b1;
        state_d       = ST_IDLE;
      end

      // root on the read port, fetch the last entry
      ST_EX0: begin
        rv_d      = rd_v;
        rk_d      = rd_k;
        h_rd_addr = AW'(cnt_m1);
        state_d   = ST_EX1;
      end

      ST_EX1: begin
        s_wr_en   = 1'b1;
        s_wr_addr = rv_q;
        s_wr_data = '0;
        cnt_d     = cnt_m1;
        cur_v_d   = rd_v;
        cur_k_d   = rd_k;
        idx_d     = '0;
        if (cnt_m1 == '0) begin
          res_d.out_vertex = rv_q;
          res_d.out_key    = ipq_pkg::KEY_W'(rk_q);
          res_d.present    = 1'b0;
          res_d.count      = '0;
          res_d.status     = ipq_pkg::STAT_OK;
          done_d           = 1'b1;
          state_d          = ST_IDLE;
        end else begin
          state_d = ST_SD_L;
        end
      end

      // sift down: hole at idx, moving entry held in cur
      ST_SD_L: begin
        if (l_w >= (CW+1)'(cnt_q)) begin
          h_wr_en          = 1'b1;
          s_wr_en          = 1'b1;
          res_d.out_vertex = rv_q;
          res_d.out_key    = ipq_pkg::KEY_W'(rk_q);
          res_d.present    = 1'b0;
          res_d.count      = ipq_pkg::COUNT_W'(cnt_q);
          res_d.status     = ipq_pkg::STAT_OK;
          done_d           = 1'b1;
          state_d          = ST_IDLE;
        end else begin
          h_rd_addr = AW'(l_w);
          state_d   = ST_SD_R;
        end
      end

      ST_SD_R: begin
        lv_d      = rd_v;
        lk_d      = rd_k;
        rok_d     = r_w < (CW+1)'(cnt_q);
        h_rd_addr = AW'(r_w);
        state_d   = ST_SD_C;
      end

      ST_SD_C: begin
        // left wins ties, child moves only if strictly smaller
        if (rok_q && rd_k < lk_q && rd_k < cur_k_q) begin
          h_wr_en   = 1'b1;
          h_wr_data = h_rd_data;
          s_wr_en   = 1'b1;
          s_wr_addr = rd_v;
          idx_d     = AW'(r_w);
          state_d   = ST_SD_L;
        end else if (lk_q < cur_k_q) begin
          h_wr_en   = 1'b1;
          h_wr_data = {lv_q, lk_q};
          s_wr_en   = 1'b1;
          s_wr_addr = lv_q;
          idx_d     = AW'(l_w);
          state_d   = ST_SD_L;
        end else begin
          h_wr_en          = 1'b1;
          s_wr_en          = 1'b1;
          res_d.out_vertex = rv_q;
          res_d.out_key    = ipq_pkg::KEY_W'(rk_q);
          res_d.present    = 1'b0;
          res_d.count      = ipq_pkg::COUNT_W'(cnt_q);
          res_d.status     = ipq_pkg::STAT_OK;
          done_d           = 1'b1;
          state_d          = ST_IDLE;
        end
      end

      // sift up: fetch the parent unless at the root
      ST_SU: begin
        if (idx_q == '0) begin
          h_wr_en       = 1'b1;
          s_wr_en       = 1'b1;
          res_d.out_key = ipq_pkg::KEY_W'(cur_k_q);
          res_d.present = 1'b1;
          res_d.status  = ipq_pkg::STAT_OK;
          done_d        = 1'b1;
          state_d       = ST_IDLE;
        end else begin
          h_rd_addr = par;
          state_d   = ST_SU_C;
        end
      end

      ST_SU_C: begin
        if (cur_k_q < rd_k) begin
          h_wr_en   = 1'b1;
          h_wr_data = h_rd_data;
          s_wr_en   = 1'b1;
          s_wr_addr = rd_v;
          idx_d     = par;
          state_d   = ST_SU;
        end else begin
          h_wr_en       = 1'b1;
          s_wr_en       = 1'b1;
          res_d.out_key = ipq_pkg::KEY_W'(cur_k_q);
          res_d.present = 1'b1;
          res_d.status  = ipq_pkg::STAT_OK;
          done_d        = 1'b1;
          state_d       = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      cnt_q   <= '0;
      op_q    <= '0;
      v_q     <= '0;
      nk_q    <= '0;
      idx_q   <= '0;
      cur_v_q <= '0;
      cur_k_q <= '0;
      lv_q    <= '0;
      lk_q    <= '0;
      rok_q   <= 1'b0;
      rv_q    <= '0;
      rk_q    <= '0;
      st_q    <= '0;
      done_q  <= 1'b0;
      res_q   <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      cnt_q   <= cnt_d;
      op_q    <= op_d;
      v_q     <= v_d;
      nk_q    <= nk_d;
      idx_q   <= idx_d;
      cur_v_q <= cur_v_d;
      cur_k_q <= cur_k_d;
      lv_q    <= lv_d;
      lk_q    <= lk_d;
      rok_q   <= rok_d;
      rv_q    <= rv_d;
      rk_q    <= rk_d;
      st_q    <= st_d;
      done_q  <= done_d;
      res_q   <= res_d;
    end
  end

  assign busy   = state_q != ST_IDLE;
  assign done_o = done_q;
  assign res_o  = res_q;

  // entry count never passes capacity
  a_cnt_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(MAX_VERTICES))
    else $error("entry count above capacity");

  // a result beat is never followed straight by another
  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("back-to-back result beats");

  // an accepted command keeps the block busy for the next cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy)
    else $error("not busy after accept");

  // empty status only with an empty heap
  a_empty_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && res_q.status == ipq_pkg::STAT_EMPTY) |-> (res_q.count == '0))
    else $error("empty status with entries left");

endmodule
`default_nettype wire

// File: dv/indexed_min_heap_priority_queue_tb.sv
// self-checking testbench for the indexed min-heap priority queue
// holds its own heap model in a scoreboard class, drives commands in random bursts
// depends on ipq_pkg and the indexed_min_heap_priority_queue rtl
`timescale 1ns / 1ps
`default_nettype none
module indexed_min_heap_priority_queue_tb;

  localparam logic [ipq_pkg::KEY_W-1:0] KEY_INF = {ipq_pkg::KEY_W{1'b1}};
  localparam int CYCLE_LIMIT = 400000;

  // heap model and queue of expected result beats
  class heap_scoreboard;
    logic [ipq_pkg::VERTEX_W-1:0] slot_vertex [ipq_pkg::MAX_VERTICES];
    logic [ipq_pkg::KEY_W-1:0]    slot_key    [ipq_pkg::MAX_VERTICES];
    int                           vertex_slot [ipq_pkg::MAX_VERTICES];
    bit                           vertex_here [ipq_pkg::MAX_VERTICES];
    int                           entries;
    ipq_pkg::res_t                pending [$];
    int                           errors;

    function void clear();
      foreach (vertex_here[i]) vertex_here[i] = 1'b0;
      entries = 0;
      errors  = 0;
    endfunction

    function void swap_slots(int a, int b);
      logic [ipq_pkg::VERTEX_W-1:0] va;
      logic [ipq_pkg::KEY_W-1:0]    ka;
      va = slot_vertex[a];
      ka = slot_key[a];
      slot_vertex[a] = slot_vertex[b];
      slot_key[a]    = slot_key[b];
      slot_vertex[b] = va;
      slot_key[b]    = ka;
      vertex_slot[slot_vertex[a]] = a;
      vertex_slot[slot_vertex[b]] = b;
    endfunction

    function void sink(int i);
      int l, r, low;
      forever begin
        l = 2 * i + 1;
        r = 2 * i + 2;
        low = i;
        if (l < entries && slot_key[l] < slot_key[i]) low = l;
        if (r < entries && slot_key[r] < slot_key[low]) low = r;
        if (low == i) return;
        swap_slots(low, i);
        i = low;
      end
    endfunction

    function void rise(int i);
      int p;
      while (i > 0) begin
        p = (i - 1) / 2;
        if (!(slot_key[i] < slot_key[p])) return;
        swap_slots(i, p);
        i = p;
      end
    endfunction

    // an accepted command beat: apply it and queue the expected result
    function void note_command(ipq_pkg::cmd_t c);
      ipq_pkg::res_t r;
      int   last;
      bit   here;
      here = vertex_here[c.vertex];
      r = '0;
      r.out_vertex = c.vertex;
      if (c.mode == ipq_pkg::MODE_EXTRACT) begin
        if (entries == 0) begin
          r.status = ipq_pkg::STAT_EMPTY;
          r.out_vertex = '0;
        end else begin
          last = entries - 1;
          r.out_vertex = slot_vertex[0];
          r.out_key    = slot_key[0];
          vertex_here[slot_vertex[0]] = 1'b0;
          slot_vertex[0] = slot_vertex[last];
          slot_key[0]    = slot_key[last];
          vertex_slot[slot_vertex[0]] = 0;
          entries = last;
          sink(0);
        end
      end else begin
        if (c.mode == ipq_pkg::MODE_INSERT) begin
          if (here || entries >= ipq_pkg::MAX_VERTICES) begin
            r.status = ipq_pkg::STAT_FULL;
          end else begin
            slot_vertex[entries] = c.vertex;
            slot_key[entries]    = KEY_INF;
            vertex_slot[c.vertex] = entries;
            vertex_here[c.vertex] = 1'b1;
            entries++;
            here = 1'b1;
          end
        end else if (!here) begin
          r.status = ipq_pkg::STAT_ABSENT;
        end else if (c.mode == ipq_pkg::MODE_SETKEY) begin
          slot_key[vertex_slot[c.vertex]] = c.new_key;
          rise(vertex_slot[c.vertex]);
        end
        if (here) begin
          r.present = 1'b1;
          r.out_key = slot_key[vertex_slot[c.vertex]];
        end
      end
      r.count = entries[ipq_pkg::COUNT_W-1:0];
      pending.push_back(r);
    endfunction

    function void check_result(ipq_pkg::res_t got);
      ipq_pkg::res_t want;
      if (pending.size() == 0) begin
        $error("result beat with nothing expected: %p", got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.out_vertex !== want.out_vertex) begin
        $error("out_vertex: expected %0d, got %0d", want.out_vertex, got.out_vertex);
        errors++;
      end
      if (got.out_key !== want.out_key) begin
        $error("out_key: expected %0d, got %0d", want.out_key, got.out_key);
        errors++;
      end
      if (got.present !== want.present) begin
        $error("present: expected %0d, got %0d", want.present, got.present);
        errors++;
      end
      if (got.count !== want.count) begin
        $error("count: expected %0d, got %0d", want.count, got.count);
        errors++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        errors++;
      end
    endfunction
  endclass

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          start = 1'b0;
  ipq_pkg::cmd_t cmd_i = '0;
  logic          busy;
  logic          done_o;
  ipq_pkg::res_t res_o;
  int            cycles = 0;

  heap_scoreboard board;

  indexed_min_heap_priority_queue uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .cmd_i  (cmd_i),
    .busy   (busy),
    .done_o (done_o),
    .res_o  (res_o)
  );

  always #2 clk_i = ~clk_i;

  // result side: every strobed beat is taken, no back-pressure possible
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (rst_ni && done_o) board.check_result(res_o);
  end

  // watchdog; the clearing pass after reset is well inside this
  always @(posedge clk_i) begin
    if (cycles >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // drive one command beat and hold it until accepted
  task automatic issue(input logic [1:0] mode, input logic [ipq_pkg::VERTEX_W-1:0] vtx,
                       input logic [ipq_pkg::KEY_W-1:0] key);
    ipq_pkg::cmd_t c;
    c.mode = mode;
    c.vertex = vtx;
    c.new_key = key;
    start <= 1'b1;
    cmd_i <= c;
    do @(posedge clk_i); while (busy);
    board.note_command(c);
  endtask

  task automatic pause(input int n);
    start <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // pick a vertex: mostly from a small pool so set-key and lookup hit present entries
  function automatic logic [ipq_pkg::VERTEX_W-1:0] pick_vertex();
    if ($urandom_range(0, 3) == 0)
      return ipq_pkg::VERTEX_W'($urandom_range(0, ipq_pkg::MAX_VERTICES - 1));
    return ipq_pkg::VERTEX_W'($urandom_range(0, 47));
  endfunction

  function automatic logic [ipq_pkg::KEY_W-1:0] pick_key();
    case ($urandom_range(0, 5))
      0: return KEY_INF;
      1: return '0;
      2: return ipq_pkg::KEY_W'($urandom_range(0, 15));
      default: return ipq_pkg::KEY_W'($urandom());
    endcase
  endfunction

  initial begin
    int sent;
    int burst;
    int pick;
    board = new();
    board.clear();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty extract, absent set-key and lookup, duplicate insert,
    // equal keys, larger key not sifted down, emptying the heap
    issue(ipq_pkg::MODE_EXTRACT, 10'd5, '0);
    issue(ipq_pkg::MODE_LOOKUP, 10'd1023, '0);
    issue(ipq_pkg::MODE_SETKEY, 10'd0, 31'd7);
    issue(ipq_pkg::MODE_INSERT, 10'd0, '0);
    issue(ipq_pkg::MODE_INSERT, 10'd1023, '0);
    issue(ipq_pkg::MODE_INSERT, 10'd0, '0);
    issue(ipq_pkg::MODE_LOOKUP, 10'd0, '0);
    issue(ipq_pkg::MODE_INSERT, 10'd512, '0);
    issue(ipq_pkg::MODE_INSERT, 10'd341, '0);
    issue(ipq_pkg::MODE_SETKEY, 10'd1023, 31'd9);
    issue(ipq_pkg::MODE_SETKEY, 10'd512, 31'd9);
    issue(ipq_pkg::MODE_SETKEY, 10'd341, '0);
    issue(ipq_pkg::MODE_SETKEY, 10'd341, KEY_INF);
    issue(ipq_pkg::MODE_SETKEY, 10'd0, 31'h2AAAAAAA);
    issue(ipq_pkg::MODE_LOOKUP, 10'd341, '0);
    issue(ipq_pkg::MODE_EXTRACT, '0, '0);
    issue(ipq_pkg::MODE_EXTRACT, '0, '0);
    issue(ipq_pkg::MODE_EXTRACT, '0, '0);
    issue(ipq_pkg::MODE_EXTRACT, '0, '0);
    issue(ipq_pkg::MODE_EXTRACT, '0, '0);
    issue(ipq_pkg::MODE_LOOKUP, 10'd512, '0);

    // hold off until the queue drains
    start <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);

    // random bursts: build up, rekey, drain, with occasional noise
    sent = 0;
    while (sent < 930) begin
      burst = $urandom_range(1, 24);
      repeat (burst) begin
        pick = $urandom_range(0, 99);
        if (pick < 30) begin
          issue(ipq_pkg::MODE_INSERT, pick_vertex(), ipq_pkg::KEY_W'($urandom()));
        end else if (pick < 55) begin
          issue(ipq_pkg::MODE_SETKEY, pick_vertex(), pick_key());
        end else if (pick < 80) begin
          issue(ipq_pkg::MODE_EXTRACT, ipq_pkg::VERTEX_W'($urandom()),
                ipq_pkg::KEY_W'($urandom()));
        end else begin
          issue(ipq_pkg::MODE_LOOKUP, pick_vertex(), ipq_pkg::KEY_W'($urandom()));
        end
        sent++;
      end
      if ($urandom_range(0, 2) != 0) pause($urandom_range(1, 40));
    end

    start <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire
